>>> rtl/core/imd_pkg.sv
// Shared constants and types for the integer matrix determinant block.
`timescale 1ns / 1ps
`default_nettype none

package imd_pkg;

	localparam int SIZE_W  = 4;
	localparam int ENTRY_W = 32;
	localparam int DET_W   = 64;
	localparam int PADDR_W = 3;

	localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

	typedef struct packed {
		logic              start;
		logic              take;
		logic [SIZE_W-1:0] order;
	} imd_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} imd_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/imd_engine.sv
// Matrix store and cofactor expansion sequencer around one shared 32x32 multiplier.
`timescale 1ns / 1ps
`default_nettype none

module imd_engine #(
	parameter int MAX_SIZE = 8,
	localparam int DEPTH = MAX_SIZE * MAX_SIZE,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  imd_pkg::imd_ctrl_t          ctrl,
	output imd_pkg::imd_stat_t          stat,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [imd_pkg::ENTRY_W-1:0] wr_data,
	output logic [imd_pkg::DET_W-1:0]   det
);
	import imd_pkg::*;

	localparam int LVL_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int CW    = $clog2(MAX_SIZE + 1);
	localparam int AXW   = AW + LVL_W + CW;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_MUL_LO = 6'b000100,
		S_MUL_HI = 6'b001000,
		S_ACC    = 6'b010000,
		S_DONE   = 6'b100000
	} imd_state_t;

	imd_state_t state_q;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic [CW-1:0]       n_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [CW-1:0]       col_q [MAX_SIZE];
	logic                par_q [MAX_SIZE];
	logic                neg_q [MAX_SIZE];
	logic [MAX_SIZE-1:0] used_q;
	logic [DET_W-1:0]    pp_q [MAX_SIZE];
	logic [DET_W-1:0]    prod_lo_q;
	logic [31:0]         cross_q;
	logic [DET_W-1:0]    sum_q;

	logic [CW-1:0]    col_cur;
	logic [LVL_W-1:0] col_idx;
	logic [LVL_W-1:0] lvl_dn;
	logic [LVL_W-1:0] lvl_up;
	logic             exhausted;
	logic             col_taken;
	logic             is_leaf;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [DET_W-1:0] base;
	logic [31:0]      mul_a;
	logic [63:0]      mul_p;
	logic [31:0]      neg_fix;
	logic [31:0]      hi_word;
	logic [DET_W-1:0] res;
	logic             sgn;
	logic [DET_W-1:0] term;

	assign col_cur   = col_q[lvl_q];
	assign col_idx   = col_cur[LVL_W-1:0];
	assign lvl_dn    = lvl_q - LVL_W'(1);
	assign lvl_up    = lvl_q + LVL_W'(1);
	assign exhausted = (col_cur == n_q);
	assign col_taken = used_q[col_idx];
	assign is_leaf   = ((CW'(lvl_q) + CW'(1)) == n_q);
	assign rd_en     = (state_q == S_SCAN) && !exhausted && !col_taken;
	assign rd_addr   = AW'(AXW'(lvl_q) * AXW'(n_q) + AXW'(col_cur));

	assign base    = (lvl_q == '0) ? DET_W'(1) : pp_q[lvl_dn];
	assign mul_a   = (state_q == S_MUL_HI) ? base[63:32] : base[31:0];
	assign mul_p   = {32'b0, mul_a} * {32'b0, rd_q};
	assign neg_fix = rd_q[31] ? base[31:0] : 32'b0;
	assign hi_word = prod_lo_q[63:32] + cross_q - neg_fix;
	assign res     = {hi_word, prod_lo_q[31:0]};
	assign sgn     = neg_q[lvl_q] ^ par_q[lvl_q];
	assign term    = sgn ? (DET_W'(0) - res) : res;

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign det       = sum_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				sum_q <= '0;
			end
			S_MUL_LO: begin
				prod_lo_q <= mul_p;
			end
			S_MUL_HI: begin
				cross_q <= mul_p[31:0];
			end
			S_ACC: begin
				pp_q[lvl_q] <= res;
				if (is_leaf) begin
					sum_q <= sum_q + term;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= CW'(1);
			lvl_q   <= '0;
			used_q  <= '0;
			for (int i = 0; i < MAX_SIZE; i++) begin
				col_q[i] <= '0;
				par_q[i] <= 1'b0;
				neg_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctrl.start) begin
						n_q      <= CW'(ctrl.order);
						lvl_q    <= '0;
						used_q   <= '0;
						col_q[0] <= '0;
						par_q[0] <= 1'b0;
						neg_q[0] <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					priority if (exhausted) begin
						if (lvl_q == '0) begin
							state_q <= S_DONE;
						end else begin
							lvl_q <= lvl_dn;
							used_q[col_q[lvl_dn][LVL_W-1:0]] <= 1'b0;
							col_q[lvl_dn] <= col_q[lvl_dn] + CW'(1);
							par_q[lvl_dn] <= ~par_q[lvl_dn];
						end
					end else if (col_taken) begin
						col_q[lvl_q] <= col_cur + CW'(1);
					end else begin
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: begin
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (is_leaf) begin
						col_q[lvl_q] <= col_cur + CW'(1);
						par_q[lvl_q] <= ~par_q[lvl_q];
					end else begin
						used_q[col_idx] <= 1'b1;
						neg_q[lvl_up]   <= sgn;
						col_q[lvl_up]   <= '0;
						par_q[lvl_up]   <= 1'b0;
						lvl_q           <= lvl_up;
					end
					state_q <= S_SCAN;
				end
				S_DONE: begin
					if (ctrl.take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/integer_matrix_determinant.sv
// Top level of the integer matrix determinant block: register port, loading and result register.
//
//  Channel      Direction  Handshake                     Payload
//  entry        in         entry_valid / entry_stall     entry (32-bit signed)
//  determinant  out        determinant_valid / _stall    determinant (64-bit signed)
//  register     in         APB write, pready tied high   matrix_size at byte address 0
//
// Each entry transfer is taken in the cycle it is offered while the block is loading.
// After the last entry, the expansion visits sum over k of n!/(n-k)! tree nodes (109,600 for
// an 8x8 matrix), each through the scan, low multiply, high multiply and accumulate states,
// plus a scan step per column test that finds a column taken and per return to the row above;
// the shared 32x32 multiplier is used twice per node.
// The entry channel stalls from the last entry until the result sits in the output register.
// Reset returns the size register to one and clears the load count; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_determinant #(
	parameter int MAX_SIZE = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [imd_pkg::PADDR_W-1:0]          paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 entry_valid,
	output logic                                 entry_stall,
	input  logic signed [imd_pkg::ENTRY_W-1:0]   entry,
	output logic                                 determinant_valid,
	input  logic                                 determinant_stall,
	output logic signed [imd_pkg::DET_W-1:0]     determinant
);
	import imd_pkg::*;

	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = $clog2(DEPTH + 1);

	logic [SIZE_W-1:0] size_q;
	logic [EW-1:0]     cnt_q;
	logic              out_valid_q;
	logic [DET_W-1:0]  det_q;

	logic              cfg_wr;
	logic              acc_in;
	logic              last;
	logic [SIZE_W-1:0] order_n;
	logic [EW-1:0]     total;
	imd_ctrl_t         ctrl;
	imd_stat_t         stat;
	logic [DET_W-1:0]  eng_det;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1] == REG_MATRIX_SIZE);
	assign prdata = (paddr[PADDR_W-1] == REG_MATRIX_SIZE) ? {28'b0, size_q} : 32'b0;

	always_comb begin
		priority if (size_q == '0) begin
			order_n = SIZE_W'(1);
		end else if (size_q > SIZE_W'(MAX_SIZE)) begin
			order_n = SIZE_W'(MAX_SIZE);
		end else begin
			order_n = size_q;
		end
	end

	assign total       = EW'(order_n) * EW'(order_n);
	assign last        = ((cnt_q + EW'(1)) == total);
	assign entry_stall = stat.busy;
	assign acc_in      = entry_valid && !entry_stall;

	assign ctrl.start = acc_in && last;
	assign ctrl.order = order_n;
	assign ctrl.take  = stat.done && (!out_valid_q || !determinant_stall);

	imd_engine #(
		.MAX_SIZE(MAX_SIZE)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.stat    (stat),
		.wr_en   (acc_in),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (entry),
		.det     (eng_det)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= SIZE_W'(1);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				size_q <= pwdata[SIZE_W-1:0];
				cnt_q  <= '0;
			end else if (acc_in) begin
				cnt_q <= last ? '0 : cnt_q + EW'(1);
			end
			if (ctrl.take) begin
				out_valid_q <= 1'b1;
			end else if (!determinant_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			det_q <= eng_det;
		end
	end

	assign determinant_valid = out_valid_q;
	assign determinant       = det_q;

endmodule

`default_nettype wire
